// ----- hw/rtl/pagq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pagq_pkg
// Shared types and constants for the gamma-2 pixel tone mapper.
// ----------------------------------------------------------------------------
package pagq_pkg;

  localparam int SUM_BITS  = 32;
  localparam int FRAC_BITS = 16;
  localparam int SPP_BITS  = 16;
  localparam int UP        = (FRAC_BITS <= 16) ? 16 - FRAC_BITS : 0;
  localparam int DOWN      = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int XW        = SUM_BITS + UP;
  localparam int XP        = (XW > 32) ? XW : 32;
  localparam int DIV_STAGES  = 16;
  localparam int SQRT_STAGES = 8;

  typedef struct packed {
    logic [SUM_BITS-1:0] red_sum;
    logic [SUM_BITS-1:0] green_sum;
    logic [SUM_BITS-1:0] blue_sum;
  } pagq_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pagq_out_t;

  // One channel after classification: saturated flag, dividend split into
  // the starting remainder and the sixteen quotient bits still to shift in.
  typedef struct packed {
    logic        sat;
    logic [15:0] hi;
    logic [15:0] lo;
  } pagq_chan_t;

  typedef struct packed {
    pagq_chan_t [2:0] ch;
  } pagq_entry_t;

endpackage

// ----- hw/rtl/pagq_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pagq_front
// Accepts a pixel, scales each sum and flags channels that saturate.
// ----------------------------------------------------------------------------
module pagq_front import pagq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  pagq_in_t            pixel,
  input  logic [SPP_BITS-1:0] spp,
  output logic                push,
  output pagq_entry_t         entry
);

  logic [SUM_BITS-1:0] sums [3];
  pagq_entry_t         entry_next;

  assign sums[0] = pixel.red_sum;
  assign sums[1] = pixel.green_sum;
  assign sums[2] = pixel.blue_sum;

  always_comb begin
    logic [XP-1:0]    x;
    logic [XP-17:0]   hi;
    entry_next = '0;
    for (int c = 0; c < 3; c++) begin
      x  = (XP'(sums[c]) << UP) >> DOWN;
      hi = x[XP-1:16];
      // index 2 of the packed array is red
      entry_next.ch[2-c].sat = (hi >= (XP-16)'(spp));
      entry_next.ch[2-c].hi  = hi[15:0];
      entry_next.ch[2-c].lo  = x[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= accept;
    end
    if (accept) begin
      entry <= entry_next;
    end
  end

endmodule

// ----- hw/rtl/pagq_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pagq_queue
// Four-entry queue between the front and the arithmetic back end.
// ----------------------------------------------------------------------------
module pagq_queue import pagq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  pagq_entry_t wdata,
  output logic        pop,
  output pagq_entry_t rdata,
  output logic        almost_full
);

  pagq_entry_t mem [4];
  logic [1:0]  wptr;
  logic [1:0]  rptr;
  logic [2:0]  count;

  assign pop         = (count != 3'd0);
  assign rdata       = mem[rptr];
  assign almost_full = (count >= 3'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 2'd1;
      if (pop)  rptr <= rptr + 2'd1;
      count <= count + {2'b0, push} - {2'b0, pop};
    end
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ----- hw/rtl/pagq_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pagq_back
// Pipelined divide by the sample count, then square root, one bit a stage.
// ----------------------------------------------------------------------------
module pagq_back import pagq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  pagq_entry_t         in_entry,
  input  logic [SPP_BITS-1:0] spp,
  output logic                done,
  output pagq_out_t           result
);

  logic        dv   [DIV_STAGES];
  logic [15:0] drem [DIV_STAGES][3];
  logic [15:0] dlo  [DIV_STAGES][3];
  logic        dsat [DIV_STAGES][3];

  logic        sv    [SQRT_STAGES];
  logic [15:0] sq    [SQRT_STAGES][3];
  logic [7:0]  sroot [SQRT_STAGES][3];
  logic        ssat  [SQRT_STAGES][3];

  always_ff @(posedge clk) begin
    logic [15:0] rem_in;
    logic [15:0] lo_in;
    logic [16:0] r;
    logic [7:0]  root_in;
    logic [7:0]  trial;
    if (rst) begin
      for (int k = 0; k < DIV_STAGES; k++)  dv[k] <= 1'b0;
      for (int k = 0; k < SQRT_STAGES; k++) sv[k] <= 1'b0;
    end else begin
      dv[0] <= in_valid;
      for (int k = 1; k < DIV_STAGES; k++)  dv[k] <= dv[k-1];
      sv[0] <= dv[DIV_STAGES-1];
      for (int k = 1; k < SQRT_STAGES; k++) sv[k] <= sv[k-1];
    end
    for (int c = 0; c < 3; c++) begin
      // restoring division: shift in one dividend bit, subtract if it fits
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem_in = (k == 0) ? in_entry.ch[2-c].hi : drem[k-1][c];
        lo_in  = (k == 0) ? in_entry.ch[2-c].lo : dlo[k-1][c];
        r      = {rem_in, lo_in[15]};
        if (r >= {1'b0, spp}) begin
          drem[k][c] <= 16'(r - {1'b0, spp});
          dlo[k][c]  <= {lo_in[14:0], 1'b1};
        end else begin
          drem[k][c] <= r[15:0];
          dlo[k][c]  <= {lo_in[14:0], 1'b0};
        end
        dsat[k][c] <= (k == 0) ? in_entry.ch[2-c].sat : dsat[k-1][c];
      end
      // square root: try each root bit from the top
      for (int k = 0; k < SQRT_STAGES; k++) begin
        root_in = (k == 0) ? 8'd0 : sroot[k-1][c];
        trial   = root_in | (8'd1 << (SQRT_STAGES - 1 - k));
        sq[k][c] <= (k == 0) ? dlo[DIV_STAGES-1][c] : sq[k-1][c];
        if ({8'd0, trial} * {8'd0, trial} <= ((k == 0) ? dlo[DIV_STAGES-1][c] : sq[k-1][c])) begin
          sroot[k][c] <= trial;
        end else begin
          sroot[k][c] <= root_in;
        end
        ssat[k][c] <= (k == 0) ? dsat[DIV_STAGES-1][c] : ssat[k-1][c];
      end
    end
  end

  assign done = sv[SQRT_STAGES-1];
  assign result.red_out   = ssat[SQRT_STAGES-1][0] ? 8'hFF : sroot[SQRT_STAGES-1][0];
  assign result.green_out = ssat[SQRT_STAGES-1][1] ? 8'hFF : sroot[SQRT_STAGES-1][1];
  assign result.blue_out  = ssat[SQRT_STAGES-1][2] ? 8'hFF : sroot[SQRT_STAGES-1][2];

endmodule

// ----- hw/rtl/pixel_average_gamma2_quantize.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_average_gamma2_quantize
// Averages accumulated RGB sums, applies gamma 2 and quantizes to 8 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Write the samples-per-pixel count through cfg_we / cfg_wdata while idle;
//   a count of zero is stored as one. Reset sets the count to one and
//   empties the pipeline.
//   Present a pixel on pixel and raise start; it is taken on an edge where
//   busy is low. One request may be issued every cycle.
//   Each result appears on result for one cycle with done high, after the
//   front register, the queue entry and the back end. The receiver cannot
//   stall, so results are never held; the front stage and queue only
//   decouple classification from the 16 division stages and 8 square root
//   stages of the back end. Throughput is one pixel per cycle.
// ----------------------------------------------------------------------------
module pixel_average_gamma2_quantize import pagq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [SPP_BITS-1:0] cfg_wdata,
  input  logic                start,
  output logic                busy,
  input  pagq_in_t            pixel,
  output logic                done,
  output pagq_out_t           result
);

  logic [SPP_BITS-1:0] spp;
  logic                push;
  logic                pop;
  logic                full;
  pagq_entry_t         fentry;
  pagq_entry_t         qentry;

  always_ff @(posedge clk) begin
    if (rst) begin
      spp <= SPP_BITS'(1);
    end else if (cfg_we) begin
      spp <= (cfg_wdata == '0) ? SPP_BITS'(1) : cfg_wdata;
    end
  end

  assign busy = full;

  pagq_front u_front (
    .clk(clk), .rst(rst), .accept(start && !busy), .pixel(pixel), .spp(spp),
    .push(push), .entry(fentry)
  );

  pagq_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(fentry),
    .pop(pop), .rdata(qentry), .almost_full(full)
  );

  pagq_back u_back (
    .clk(clk), .rst(rst), .in_valid(pop), .in_entry(qentry), .spp(spp),
    .done(done), .result(result)
  );

endmodule

// ----- hw/rtl/pagq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pagq_checker
// Port-level checks on request-to-result timing, on done after reset and on busy.
// ----------------------------------------------------------------------------
module pagq_checker import pagq_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  localparam int LAT = 26;

  a_no_done_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done) else $error("result strobe right after reset");

  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, LAT))
    else $error("result without a matching request");

  a_request_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done) else $error("request lost");

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy) else $error("queue backed up");

endmodule

bind pixel_average_gamma2_quantize pagq_checker u_pagq_checker (.*);

// ----- bench/pixel_average_gamma2_quantize_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_average_gamma2_quantize_tb
// Drives directed and random pixels through the gamma-2 tone mapper under
// several samples-per-pixel settings and sender gap patterns, and compares
// every result with an exact integer prediction of the three channels.
// ----------------------------------------------------------------------------
module pixel_average_gamma2_quantize_tb;
  import pagq_pkg::*;

  localparam int LATENCY = 26;

  typedef struct {
    logic [31:0] r;
    logic [31:0] g;
    logic [31:0] b;
    bit          known;
    logic [7:0]  er;
    logic [7:0]  eg;
    logic [7:0]  eb;
  } vec_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        start;
  logic        busy;
  pagq_in_t    pixel;
  logic        done;
  pagq_out_t   result;

  logic [15:0] spp_model;
  pagq_out_t   pending_pixels[$];
  int          errors;
  int          gap_pct;

  pixel_average_gamma2_quantize i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .pixel(pixel), .done(done), .result(result)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("pixel_average_gamma2_quantize_tb: FAIL");
    $finish;
  end

  function automatic logic [7:0] tone(input logic [31:0] sum, input logic [15:0] spp);
    logic [63:0] q;
    logic [8:0]  root;
    logic [8:0]  trial;
    q = {32'd0, sum} / ((spp == 0) ? 64'd1 : {48'd0, spp});
    if (q >= 64'd65536) return 8'd255;
    root = 0;
    for (int b = 7; b >= 0; b--) begin
      trial = root | (9'd1 << b);
      if ({55'd0, trial} * {55'd0, trial} <= q) root = trial;
    end
    return root[7:0];
  endfunction

  function automatic pagq_out_t tone_pixel(input logic [31:0] r, g, b);
    pagq_out_t o;
    o.red_out   = tone(r, spp_model);
    o.green_out = tone(g, spp_model);
    o.blue_out  = tone(b, spp_model);
    return o;
  endfunction

  // check every strobed result against the oldest prediction
  always @(posedge clk) begin
    pagq_out_t want;
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (result.red_out !== want.red_out) begin
          $display("%0t: red expected %0d actual %0d", $time, want.red_out, result.red_out);
          errors++;
        end
        if (result.green_out !== want.green_out) begin
          $display("%0t: green expected %0d actual %0d", $time, want.green_out,
                   result.green_out);
          errors++;
        end
        if (result.blue_out !== want.blue_out) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.blue_out,
                   result.blue_out);
          errors++;
        end
      end
    end
  end

  task automatic write_spp(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    spp_model = v;
  endtask

  task automatic send_pixel(input logic [31:0] r, g, b, input bit known = 0,
                            input pagq_out_t fixed = '0);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pixel <= '{red_sum: r, green_sum: g, blue_sum: b};
    do @(posedge clk); while (busy);
    pending_pixels.push_back(known ? fixed : tone_pixel(r, g, b));
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sum(input logic [15:0] spp);
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(32'h0001_0000) * ((spp == 0) ? 1 : spp);
      2: return $urandom_range(255);
      default: return 32'({32'd0, $urandom} % (({48'd0, spp} + 64'd1) << 16));
    endcase
  endfunction

  vec_t directed[] = '{
    '{32'h0,          32'h0,          32'h0,          1, 8'd0,   8'd0,   8'd0},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1, 8'd255, 8'd255, 8'd255},
    '{32'h0001_0000,  32'h0000_FFFF,  32'h0000_0001,  1, 8'd255, 8'd255, 8'd1},
    '{32'h0000_4000,  32'h0000_0004,  32'h0000_0100,  1, 8'd128, 8'd2,   8'd16},
    '{32'h0000_FE01,  32'h0000_FE00,  32'h8000_0000,  1, 8'd255, 8'd254, 8'd255},
    '{32'hAAAA_AAAA,  32'h5555_5555,  32'h0000_3FFF,  0, 8'd0,   8'd0,   8'd0},
    '{32'h0000_0003,  32'h0000_0008,  32'h0000_9000,  0, 8'd0,   8'd0,   8'd0}
  };

  logic [15:0] spp_set[] = '{16'd1, 16'd0, 16'd65535, 16'd3, 16'd64, 16'd1000, 16'd2};
  int          gap_set[] = '{0, 48, 6, 0, 48, 6, 0};

  initial begin
    errors    = 0;
    gap_pct   = 0;
    spp_model = 16'd1;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    start     <= 1'b0;
    pixel     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at reset count of one
    foreach (directed[i])
      send_pixel(directed[i].r, directed[i].g, directed[i].b, directed[i].known,
                 '{red_out: directed[i].er, green_out: directed[i].eg,
                   blue_out: directed[i].eb});
    drain();

    foreach (spp_set[p]) begin
      write_spp(spp_set[p]);
      gap_pct = gap_set[p];
      for (int i = 0; i < 5; i++)
        send_pixel(directed[i].r, directed[i].g, directed[i].b);
      for (int i = 0; i < 125; i++)
        send_pixel(rand_sum(spp_model), rand_sum(spp_model), rand_sum(spp_model));
      drain();
    end

    if (errors == 0)
      $display("pixel_average_gamma2_quantize_tb: PASS");
    else
      $display("pixel_average_gamma2_quantize_tb: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/pagq_pkg.sv
hw/rtl/pagq_front.sv
hw/rtl/pagq_queue.sv
hw/rtl/pagq_back.sv
hw/rtl/pixel_average_gamma2_quantize.sv
hw/rtl/pagq_checker.sv
bench/pixel_average_gamma2_quantize_tb.sv
